[rtl/assert_macros.svh]
// Assertion macros for the RTL file that carries concurrent checks.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/fcbp_pkg.sv]
// Package for the framed command byte parser: sizes, character codes, types.
// Used by fcbp_front, fcbp_queue, fcbp_back and framed_command_byte_parser.
`timescale 1ns / 1ps

package fcbp_pkg;

  localparam int unsigned FrameCap    = 49;
  localparam int unsigned LedFrameLen = 18;
  localparam int unsigned FrameLenW   = $clog2(FrameCap + 1);

  localparam int unsigned WheelTokens = 2;
  localparam int unsigned LedTokens   = 4;
  localparam int unsigned WheelCntW   = $clog2(WheelTokens + 1);
  localparam int unsigned LedCntW     = $clog2(LedTokens + 1);
  localparam int unsigned WheelMagW   = 9;
  localparam int unsigned LedMagW     = 17;

  localparam logic [WheelMagW-1:0] WheelMagMax = '1;
  localparam logic [LedMagW-1:0]   LedMagMax   = '1;
  localparam logic [7:0]           ByteMax     = 8'hFF;
  localparam logic [15:0]          IndexMax    = 16'hFFFF;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [7:0] ChLBrack = 8'h5B;
  localparam logic [7:0] ChRBrack = 8'h5D;
  localparam logic [7:0] ChLAngle = 8'h3C;
  localparam logic [7:0] ChRAngle = 8'h3E;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperZ = 8'h5A;
  localparam logic [7:0] ChUpperL = 8'h4C;

  typedef enum logic [1:0] {
    SCAN_BETWEEN = 2'd0,
    SCAN_SIGN    = 2'd1,
    SCAN_DIGITS  = 2'd2,
    SCAN_STOPPED = 2'd3
  } scan_phase_e;

  typedef enum logic [1:0] {
    CMD_MOTOR = 2'd0,
    CMD_LED   = 2'd1,
    CMD_GAME  = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e                              kind;
    logic [WheelCntW-1:0]                   wheel_cnt;
    logic [WheelTokens-1:0]                 wheel_neg;
    logic [WheelTokens-1:0][WheelMagW-1:0]  wheel_mag;
    logic [LedCntW-1:0]                     led_cnt;
    logic [LedTokens-1:0]                   led_neg;
    logic [LedTokens-1:0][LedMagW-1:0]      led_mag;
    logic [7:0]                             letter;
  } cmd_t;

  typedef struct packed {
    cmd_kind_e   kind;
    logic        left_forward;
    logic [7:0]  left_speed;
    logic        right_forward;
    logic [7:0]  right_speed;
    logic [15:0] pixel_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  game_letter;
  } res_t;

  // Appends one decimal digit to a magnitude and saturates at mag_max.
  function automatic logic [LedMagW-1:0] mag_append(logic [LedMagW-1:0] mag,
                                                    logic [7:0] ch,
                                                    logic [LedMagW-1:0] mag_max);
    logic [LedMagW+3:0] wide;
    wide = ({4'd0, mag} << 3) + ({4'd0, mag} << 1) + {{LedMagW{1'b0}}, ch[3:0]};
    if (wide > {4'd0, mag_max}) begin
      return mag_max;
    end
    return wide[LedMagW-1:0];
  endfunction

endpackage

[rtl/framed_command_byte_parser.sv]
// Top level of the framed command byte parser: front end, queue, back end.
// Depends on fcbp_pkg, fcbp_front, fcbp_queue, fcbp_back and assert_macros.svh.
//
//   Channel  Handshake              Payload
//   rx       rx_valid_i/rx_ready_o  rx_byte_i
//   res      res_valid_o/res_ready_i cmd_kind_o, wheel, LED and game fields
//
// One byte beat is taken every cycle while the command queue has room.
// A terminator's command is written into the queue, then loaded into the free output register.
// The queue holds two commands, so a stalled result holds the front end off
// only after two more terminators arrive. Reset clears the frame and the queue.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module framed_command_byte_parser import fcbp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rx_valid_i,
  output logic        rx_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output logic [1:0]  cmd_kind_o,
  output logic        left_forward_o,
  output logic [7:0]  left_speed_o,
  output logic        right_forward_o,
  output logic [7:0]  right_speed_o,
  output logic [15:0] pixel_index_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [7:0]  game_letter_o
);

  logic q_push, q_pop, q_full, q_valid;
  cmd_t push_cmd, head_cmd;
  res_t res;

  fcbp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_valid_i),
    .rx_byte_i  (rx_byte_i),
    .q_full_i   (q_full),
    .rx_ready_o (rx_ready_o),
    .push_o     (q_push),
    .cmd_o      (push_cmd)
  );

  fcbp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .cmd_o   (head_cmd)
  );

  fcbp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (head_cmd),
    .res_ready_i (res_ready_i),
    .pop_o       (q_pop),
    .res_valid_o (res_valid_o),
    .res_o       (res)
  );

  assign cmd_kind_o      = res.kind;
  assign left_forward_o  = res.left_forward;
  assign left_speed_o    = res.left_speed;
  assign right_forward_o = res.right_forward;
  assign right_speed_o   = res.right_speed;
  assign pixel_index_o   = res.pixel_index;
  assign red_o           = res.red;
  assign green_o         = res.green;
  assign blue_o          = res.blue;
  assign game_letter_o   = res.game_letter;

  `ASSERT_IMPL(a_no_push_when_full, q_push, !q_full, "command pushed into a full queue")
  `ASSERT_IMPL(a_no_pop_when_empty, q_pop, q_valid, "command popped from an empty queue")
  `ASSERT_NEXT(a_push_lands, q_push && !q_pop, q_valid, "pushed command missing from queue")
  `ASSERT_IMPL(a_motor_fields_clean, res_valid_o && (cmd_kind_o == CMD_MOTOR),
    (pixel_index_o == '0) && (red_o == '0) && (game_letter_o == '0),
    "motor result carries LED or game data")

endmodule

[rtl/fcbp_front.sv]
// Front end: accepts received bytes, tracks the frame and both token scans.
// Pushes one command record per terminator byte. Depends on fcbp_pkg.
`timescale 1ns / 1ps

module fcbp_front import fcbp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rx_valid_i,
  input  logic [7:0] rx_byte_i,
  input  logic       q_full_i,
  output logic       rx_ready_o,
  output logic       push_o,
  output cmd_t       cmd_o
);

  logic [FrameLenW-1:0]                  len_q, len_b, len_d;
  logic [7:0]                            second_q, second_b, second_d;
  logic [WheelCntW-1:0]                  wcnt_q, wcnt_b, wcnt_d;
  logic [WheelTokens-1:0]                wneg_q, wneg_b, wneg_d;
  logic [WheelTokens-1:0][WheelMagW-1:0] wmag_q, wmag_b, wmag_d;
  scan_phase_e                           wph_q, wph_b, wph_d;
  logic [LedCntW-1:0]                    lcnt_q, lcnt_b, lcnt_d;
  logic [LedTokens-1:0]                  lneg_q, lneg_b, lneg_d;
  logic [LedTokens-1:0][LedMagW-1:0]     lmag_q, lmag_b, lmag_d;
  scan_phase_e                           lph_q, lph_b, lph_d;

  logic accept, is_term, is_start, is_body, is_digit, is_sign, clear, do_app;
  logic w_delim, l_delim;

  assign rx_ready_o = !q_full_i;
  assign accept     = rx_valid_i && rx_ready_o;

  assign is_digit = (rx_byte_i >= ChZero) && (rx_byte_i <= ChNine);
  assign is_sign  = (rx_byte_i == ChPlus) || (rx_byte_i == ChMinus);
  assign is_term  = (rx_byte_i == ChRBrack) || (rx_byte_i == ChRAngle);
  assign is_start = (rx_byte_i == ChLBrack) || (rx_byte_i == ChLAngle);
  assign is_body  = ((rx_byte_i >= ChUpperA) && (rx_byte_i <= ChUpperZ)) || is_digit ||
                    (rx_byte_i == ChComma) || is_sign;
  assign clear    = is_start || (!is_term && !is_body);
  assign w_delim  = (rx_byte_i == ChComma) || (rx_byte_i == ChLBrack) ||
                    (rx_byte_i == ChRBrack);
  assign l_delim  = (rx_byte_i == ChComma) || (rx_byte_i == ChRAngle);

  always_comb begin
    if (clear) begin
      len_b    = '0;
      second_b = '0;
      wcnt_b   = '0;
      wneg_b   = '0;
      wmag_b   = '0;
      wph_b    = SCAN_BETWEEN;
      lcnt_b   = '0;
      lneg_b   = '0;
      lmag_b   = '0;
      lph_b    = SCAN_BETWEEN;
    end else begin
      len_b    = len_q;
      second_b = second_q;
      wcnt_b   = wcnt_q;
      wneg_b   = wneg_q;
      wmag_b   = wmag_q;
      wph_b    = wph_q;
      lcnt_b   = lcnt_q;
      lneg_b   = lneg_q;
      lmag_b   = lmag_q;
      lph_b    = lph_q;
    end
  end

  assign do_app = (is_term || is_body || is_start) && (len_b < FrameLenW'(FrameCap));

  always_comb begin
    len_d    = len_b;
    second_d = second_b;
    wcnt_d   = wcnt_b;
    wneg_d   = wneg_b;
    wmag_d   = wmag_b;
    wph_d    = wph_b;
    lcnt_d   = lcnt_b;
    lneg_d   = lneg_b;
    lmag_d   = lmag_b;
    lph_d    = lph_b;
    if (do_app) begin
      len_d = len_b + FrameLenW'(1);
      if (len_b == FrameLenW'(1)) begin
        second_d = rx_byte_i;
      end
      if (w_delim) begin
        wph_d = SCAN_BETWEEN;
      end else begin
        case (wph_b)
          SCAN_BETWEEN: begin
            if (wcnt_b >= WheelCntW'(WheelTokens)) begin
              wph_d = SCAN_STOPPED;
            end else begin
              for (int i = 0; i < WheelTokens; i++) begin
                if (wcnt_b == WheelCntW'(i)) begin
                  wneg_d[i] = (rx_byte_i == ChMinus);
                  wmag_d[i] = is_digit ? WheelMagW'(rx_byte_i[3:0]) : '0;
                end
              end
              wcnt_d = wcnt_b + WheelCntW'(1);
              wph_d  = is_sign ? SCAN_SIGN : (is_digit ? SCAN_DIGITS : SCAN_STOPPED);
            end
          end
          SCAN_SIGN, SCAN_DIGITS: begin
            if (is_digit) begin
              for (int i = 0; i < WheelTokens; i++) begin
                if (wcnt_b == WheelCntW'(i + 1)) begin
                  wmag_d[i] = WheelMagW'(mag_append(LedMagW'(wmag_b[i]), rx_byte_i,
                                                    LedMagW'(WheelMagMax)));
                end
              end
              wph_d = SCAN_DIGITS;
            end else begin
              wph_d = SCAN_STOPPED;
            end
          end
          default: begin
            wph_d = wph_b;
          end
        endcase
      end
      if (len_b >= FrameLenW'(2)) begin
        if (l_delim) begin
          lph_d = SCAN_BETWEEN;
        end else begin
          case (lph_b)
            SCAN_BETWEEN: begin
              if (lcnt_b >= LedCntW'(LedTokens)) begin
                lph_d = SCAN_STOPPED;
              end else begin
                for (int i = 0; i < LedTokens; i++) begin
                  if (lcnt_b == LedCntW'(i)) begin
                    lneg_d[i] = (rx_byte_i == ChMinus);
                    lmag_d[i] = is_digit ? LedMagW'(rx_byte_i[3:0]) : '0;
                  end
                end
                lcnt_d = lcnt_b + LedCntW'(1);
                lph_d  = is_sign ? SCAN_SIGN : (is_digit ? SCAN_DIGITS : SCAN_STOPPED);
              end
            end
            SCAN_SIGN, SCAN_DIGITS: begin
              if (is_digit) begin
                for (int i = 0; i < LedTokens; i++) begin
                  if (lcnt_b == LedCntW'(i + 1)) begin
                    lmag_d[i] = mag_append(lmag_b[i], rx_byte_i, LedMagMax);
                  end
                end
                lph_d = SCAN_DIGITS;
              end else begin
                lph_d = SCAN_STOPPED;
              end
            end
            default: begin
              lph_d = lph_b;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      second_q <= '0;
      wcnt_q   <= '0;
      wneg_q   <= '0;
      wmag_q   <= '0;
      wph_q    <= SCAN_BETWEEN;
      lcnt_q   <= '0;
      lneg_q   <= '0;
      lmag_q   <= '0;
      lph_q    <= SCAN_BETWEEN;
    end else if (accept) begin
      len_q    <= len_d;
      second_q <= second_d;
      wcnt_q   <= wcnt_d;
      wneg_q   <= wneg_d;
      wmag_q   <= wmag_d;
      wph_q    <= wph_d;
      lcnt_q   <= lcnt_d;
      lneg_q   <= lneg_d;
      lmag_q   <= lmag_d;
      lph_q    <= lph_d;
    end
  end

  assign push_o = accept && is_term;

  always_comb begin
    cmd_o           = '0;
    cmd_o.wheel_cnt = wcnt_d;
    cmd_o.wheel_neg = wneg_d;
    cmd_o.wheel_mag = wmag_d;
    cmd_o.led_cnt   = lcnt_d;
    cmd_o.led_neg   = lneg_d;
    cmd_o.led_mag   = lmag_d;
    cmd_o.letter    = second_d;
    if (rx_byte_i == ChRBrack) begin
      cmd_o.kind = CMD_MOTOR;
    end else if ((len_d == FrameLenW'(LedFrameLen)) && (second_d == ChUpperL)) begin
      cmd_o.kind = CMD_LED;
    end else begin
      cmd_o.kind = CMD_GAME;
    end
  end

endmodule

[rtl/fcbp_queue.sv]
// Short command queue between the front end and the back end.
// Holds fcbp_pkg::cmd_t records; depth set by fcbp_pkg::QueueDepth.
`timescale 1ns / 1ps

module fcbp_queue import fcbp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output logic full_o,
  output logic valid_o,
  output cmd_t cmd_o
);

  cmd_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0
                                                             : wr_ptr_q + QueuePtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0
                                                             : rd_ptr_q + QueuePtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QueueCntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QueueCntW'(1);
      end
    end
  end

  assign full_o  = (cnt_q == QueueCntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];

endmodule

[rtl/fcbp_back.sv]
// Back end: turns queued command records into clamped result beats.
// Owns the output register and handshake. Depends on fcbp_pkg.
`timescale 1ns / 1ps

module fcbp_back import fcbp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  input  logic res_ready_i,
  output logic pop_o,
  output logic res_valid_o,
  output res_t res_o
);

  logic                                  res_valid_q;
  res_t                                  res_q, res_d;
  logic                                  load, keep;
  logic [WheelTokens-1:0]                wneg;
  logic [WheelTokens-1:0][WheelMagW-1:0] wmag;
  logic [LedTokens-1:0]                  lneg;
  logic [LedTokens-1:0][LedMagW-1:0]     lmag;

  always_comb begin
    for (int i = 0; i < WheelTokens; i++) begin
      wmag[i] = (cmd_i.wheel_cnt > WheelCntW'(i)) ? cmd_i.wheel_mag[i] : '0;
      wneg[i] = (cmd_i.wheel_cnt > WheelCntW'(i)) && cmd_i.wheel_neg[i] && (wmag[i] != '0);
    end
    for (int i = 0; i < LedTokens; i++) begin
      lmag[i] = (cmd_i.led_cnt > LedCntW'(i)) ? cmd_i.led_mag[i] : '0;
      lneg[i] = (cmd_i.led_cnt > LedCntW'(i)) && cmd_i.led_neg[i] && (lmag[i] != '0);
    end
  end

  always_comb begin
    res_d      = '0;
    res_d.kind = cmd_i.kind;
    keep       = 1'b1;
    case (cmd_i.kind)
      CMD_MOTOR: begin
        res_d.left_forward  = !wneg[0];
        res_d.left_speed    = (wmag[0] > WheelMagW'(ByteMax)) ? ByteMax : wmag[0][7:0];
        res_d.right_forward = !wneg[1];
        res_d.right_speed   = (wmag[1] > WheelMagW'(ByteMax)) ? ByteMax : wmag[1][7:0];
      end
      CMD_LED: begin
        keep              = !lneg[0];
        res_d.pixel_index = (lmag[0] > LedMagW'(IndexMax)) ? IndexMax : lmag[0][15:0];
        res_d.red   = lneg[1] ? '0 : ((lmag[1] > LedMagW'(ByteMax)) ? ByteMax : lmag[1][7:0]);
        res_d.green = lneg[2] ? '0 : ((lmag[2] > LedMagW'(ByteMax)) ? ByteMax : lmag[2][7:0]);
        res_d.blue  = lneg[3] ? '0 : ((lmag[3] > LedMagW'(ByteMax)) ? ByteMax : lmag[3][7:0]);
      end
      default: begin
        res_d.game_letter = cmd_i.letter;
      end
    endcase
  end

  assign load  = cmd_valid_i && (!res_valid_q || res_ready_i);
  assign pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (load) begin
      res_valid_q <= keep;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
